// File: hdl/spb_pkg.sv
// ----------------------------------------------------------------------------
// spb_pkg
// Shared types, reset values, register map and fixed-point helpers for the
// ballistic spark position unit.
// ----------------------------------------------------------------------------
`default_nettype none

package spb_pkg;

   localparam int unsigned FRAC_BITS_DEFAULT = 16;
   localparam int unsigned FX_W              = 32;
   localparam int unsigned LANES             = 4;
   localparam int unsigned ADDR_W            = 5;

   typedef logic signed [FX_W-1:0] fx_type;

   // lane order inside the position and velocity vectors
   localparam int unsigned LANE_X      = 0;
   localparam int unsigned LANE_Y      = 1;
   localparam int unsigned LANE_Z      = 2;
   localparam int unsigned LANE_BOUNCE = 3;

   typedef enum logic [2:0] {
      REG_DURATION     = 3'd0,
      REG_INITIAL      = 3'd1,
      REG_TERMINAL     = 3'd2,
      REG_HALF_SLOPE   = 3'd3,
      REG_HALF_GRAVITY = 3'd4
   } reg_index_type;

   localparam logic [30:0] DURATION_RESET = 31'd65536;
   localparam fx_type      SCALE_RESET    = 32'sd65536;
   localparam fx_type      ZERO_RESET     = 32'sd0;

   localparam fx_type FX_MAX = 32'sh7FFF_FFFF;
   localparam fx_type FX_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic [30:0] duration;
      fx_type      initial_scale;
      fx_type      terminal_scale;
      fx_type      half_slope;
      fx_type      half_gravity;
   } cfg_type;

   typedef struct packed {
      fx_type [LANES-1:0] pos;
      fx_type [LANES-1:0] vel;
   } particle_type;

   typedef struct packed {
      particle_type part;
      fx_type       s;
      fx_type       g;
   } scaled_type;

   // clamp a 64-bit value to the signed 32-bit range
   function automatic fx_type sat64(input logic signed [63:0] v);
      fx_type r;
      if (&v[63:31] || ~|v[63:31]) begin
         r = v[31:0];
      end else if (v[63]) begin
         r = FX_MIN;
      end else begin
         r = FX_MAX;
      end
      return r;
   endfunction

   // clamp a 33-bit sum to the signed 32-bit range
   function automatic fx_type sat33(input logic [32:0] v);
      fx_type r;
      if (v[32] == v[31]) begin
         r = v[31:0];
      end else if (v[32]) begin
         r = FX_MIN;
      end else begin
         r = FX_MAX;
      end
      return r;
   endfunction

   // product, low fraction bits dropped (floor), saturated
   function automatic fx_type fmul(input fx_type a, input fx_type b,
                                   input int unsigned frac);
      logic signed [63:0] p;
      logic signed [63:0] q;
      p = a * b;
      q = p >>> frac;
      return sat64(q);
   endfunction

   function automatic fx_type fadd(input fx_type a, input fx_type b);
      logic [32:0] sum;
      sum = {a[FX_W-1], a} + {b[FX_W-1], b};
      return sat33(sum);
   endfunction

   function automatic fx_type fsub(input fx_type a, input fx_type b);
      logic [32:0] dif;
      dif = {a[FX_W-1], a} - {b[FX_W-1], b};
      return sat33(dif);
   endfunction

endpackage

`default_nettype wire

// File: hdl/spb_csr.sv
// ----------------------------------------------------------------------------
// spb_csr
// Register bank behind the bus port: ramp duration, velocity scales,
// half slope and half gravity.
// ----------------------------------------------------------------------------
`default_nettype none

module spb_csr
   import spb_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output cfg_type           cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type index;

   assign index = reg_index_type'(paddr[ADDR_W-1:2]);

   always_comb begin
      cfg_in = cfg_ff;
      if (psel && penable && pwrite) begin
         unique case (index)
            REG_DURATION:     cfg_in.duration       = pwdata[30:0];
            REG_INITIAL:      cfg_in.initial_scale  = pwdata;
            REG_TERMINAL:     cfg_in.terminal_scale = pwdata;
            REG_HALF_SLOPE:   cfg_in.half_slope     = pwdata;
            REG_HALF_GRAVITY: cfg_in.half_gravity   = pwdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.duration       <= DURATION_RESET;
         cfg_ff.initial_scale  <= SCALE_RESET;
         cfg_ff.terminal_scale <= SCALE_RESET;
         cfg_ff.half_slope     <= ZERO_RESET;
         cfg_ff.half_gravity   <= ZERO_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (index)
         REG_DURATION:     prdata = {1'b0, cfg_ff.duration};
         REG_INITIAL:      prdata = cfg_ff.initial_scale;
         REG_TERMINAL:     prdata = cfg_ff.terminal_scale;
         REG_HALF_SLOPE:   prdata = cfg_ff.half_slope;
         REG_HALF_GRAVITY: prdata = cfg_ff.half_gravity;
         default:          prdata = 32'd0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// File: hdl/spb_scale.sv
// ----------------------------------------------------------------------------
// spb_scale
// Five-stage pipeline that forms the drag displacement factor s and the
// gravity term g for each particle.
// ----------------------------------------------------------------------------
`default_nettype none

module spb_scale
   import spb_pkg::*;
#(
   parameter int unsigned FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  logic         in_valid,
   output logic         in_ready,
   input  particle_type in_part,
   input  fx_type       in_age,
   output logic         out_valid,
   input  logic         out_ready,
   output scaled_type   out_data
);

   localparam int unsigned STAGES = 5;

   logic [STAGES-1:0] v_ff;
   logic [STAGES-1:0] v_in;
   logic [STAGES-1:0] en;

   fx_type dur_s;

   // stage 0: particle, lo and hi
   particle_type part0_ff;
   fx_type       age0_ff, lo0_ff, hi0_ff;
   fx_type       lo0_in, hi0_in;
   // stage 1: first products
   particle_type part1_ff;
   fx_type       lo_i1_ff, hi_t1_ff, lolo1_ff, dt1_ff, aa1_ff;
   fx_type       lo_i1_in, hi_t1_in, lolo1_in, dt1_in, aa1_in;
   // stage 2: second products and first sum
   particle_type part2_ff;
   fx_type       sa2_ff, q2_ff, g2_ff, dt2_ff;
   fx_type       sa2_in, q2_in, g2_in;
   // stage 3
   particle_type part3_ff;
   fx_type       sb3_ff, g3_ff, dt3_ff;
   fx_type       sb3_in;
   // stage 4
   particle_type part4_ff;
   fx_type       s4_ff, g4_ff;
   fx_type       s4_in;

   // a stage moves when it is empty or the next one moves
   always_comb begin
      en[STAGES-1] = !v_ff[STAGES-1] || out_ready;
      for (int k = STAGES - 2; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
      v_in[0] = en[0] ? in_valid : v_ff[0];
      for (int k = 1; k < STAGES; k++) begin
         v_in[k] = en[k] ? v_ff[k-1] : v_ff[k];
      end
   end

   assign in_ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign dur_s = {1'b0, cfg.duration};

   always_comb begin
      lo0_in   = (in_age < dur_s) ? in_age : dur_s;
      hi0_in   = (in_age > dur_s) ? in_age : dur_s;
      lo_i1_in = fmul(lo0_ff, cfg.initial_scale, FRAC_BITS);
      hi_t1_in = fmul(hi0_ff, cfg.terminal_scale, FRAC_BITS);
      lolo1_in = fmul(lo0_ff, lo0_ff, FRAC_BITS);
      dt1_in   = fmul(dur_s, cfg.terminal_scale, FRAC_BITS);
      aa1_in   = fmul(age0_ff, age0_ff, FRAC_BITS);
      sa2_in   = fadd(lo_i1_ff, hi_t1_ff);
      q2_in    = fmul(lolo1_ff, cfg.half_slope, FRAC_BITS);
      g2_in    = fmul(cfg.half_gravity, aa1_ff, FRAC_BITS);
      sb3_in   = fadd(sa2_ff, q2_ff);
      s4_in    = fsub(sb3_ff, dt3_ff);
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         part0_ff <= in_part;
         age0_ff  <= in_age;
         lo0_ff   <= lo0_in;
         hi0_ff   <= hi0_in;
      end
      if (en[1]) begin
         part1_ff <= part0_ff;
         lo_i1_ff <= lo_i1_in;
         hi_t1_ff <= hi_t1_in;
         lolo1_ff <= lolo1_in;
         dt1_ff   <= dt1_in;
         aa1_ff   <= aa1_in;
      end
      if (en[2]) begin
         part2_ff <= part1_ff;
         sa2_ff   <= sa2_in;
         q2_ff    <= q2_in;
         g2_ff    <= g2_in;
         dt2_ff   <= dt1_ff;
      end
      if (en[3]) begin
         part3_ff <= part2_ff;
         sb3_ff   <= sb3_in;
         g3_ff    <= g2_ff;
         dt3_ff   <= dt2_ff;
      end
      if (en[4]) begin
         part4_ff <= part3_ff;
         s4_ff    <= s4_in;
         g4_ff    <= g3_ff;
      end
   end

   assign out_valid     = v_ff[STAGES-1];
   assign out_data.part = part4_ff;
   assign out_data.s    = s4_ff;
   assign out_data.g    = g4_ff;

endmodule

`default_nettype wire

// File: hdl/spb_lanes.sv
// ----------------------------------------------------------------------------
// spb_lanes
// Three-stage pipeline that moves the four lanes by velocity times s, adds
// gravity on the vertical and bounce lanes and picks the higher track.
// ----------------------------------------------------------------------------
`default_nettype none

module spb_lanes
   import spb_pkg::*;
#(
   parameter int unsigned FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  scaled_type in_data,
   output logic       out_valid,
   input  logic       out_ready,
   output fx_type     out_x,
   output fx_type     out_y,
   output fx_type     out_z,
   output fx_type     out_bounce
);

   localparam int unsigned STAGES = 3;

   logic [STAGES-1:0] v_ff;
   logic [STAGES-1:0] v_in;
   logic [STAGES-1:0] en;

   fx_type [LANES-1:0] pos0_ff, m0_ff, m0_in;
   fx_type             g0_ff;
   fx_type [LANES-1:0] lane1_ff, lane1_in;
   fx_type             g1_ff;
   fx_type             x2_ff, y2_ff, z2_ff, b2_ff;
   fx_type             vert2, x2_in, y2_in, z2_in, b2_in;

   always_comb begin
      en[STAGES-1] = !v_ff[STAGES-1] || out_ready;
      for (int k = STAGES - 2; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
      v_in[0] = en[0] ? in_valid : v_ff[0];
      for (int k = 1; k < STAGES; k++) begin
         v_in[k] = en[k] ? v_ff[k-1] : v_ff[k];
      end
   end

   assign in_ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         m0_in[i]    = fmul(in_data.part.vel[i], in_data.s, FRAC_BITS);
         lane1_in[i] = fadd(pos0_ff[i], m0_ff[i]);
      end
      x2_in = lane1_ff[LANE_X];
      z2_in = lane1_ff[LANE_Z];
      vert2 = fadd(lane1_ff[LANE_Y], g1_ff);
      b2_in = fadd(lane1_ff[LANE_BOUNCE], g1_ff);
      // ties go to the bounce track
      y2_in = (vert2 > b2_in) ? vert2 : b2_in;
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         pos0_ff <= in_data.part.pos;
         m0_ff   <= m0_in;
         g0_ff   <= in_data.g;
      end
      if (en[1]) begin
         lane1_ff <= lane1_in;
         g1_ff    <= g0_ff;
      end
      if (en[2]) begin
         x2_ff <= x2_in;
         y2_ff <= y2_in;
         z2_ff <= z2_in;
         b2_ff <= b2_in;
      end
   end

   assign out_valid  = v_ff[STAGES-1];
   assign out_x      = x2_ff;
   assign out_y      = y2_ff;
   assign out_z      = z2_ff;
   assign out_bounce = b2_ff;

endmodule

`default_nettype wire

// File: hdl/spark_ballistic_position_unit.sv
// ----------------------------------------------------------------------------
// spark_ballistic_position_unit
// Fixed-point ballistic position of one spark per transaction.
// ----------------------------------------------------------------------------
// Takes one particle per clock when the output side keeps up and returns one
// position per particle, in order. The pipeline has one registered stage for
// each step of the multiplier chain: lo/hi select, first products, slope and
// gravity products, a saturating sum and a saturating difference for the drag
// factor, the per-lane velocity product, the position add and the gravity
// add with the track select. Stalls on the result side fill the empty stages
// first and only then hold the input side. All values are signed fixed point
// with FRAC_BITS fraction bits; products drop the low bits and every result
// saturates. Registers are to be written by the user only while no
// transaction is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module spark_ballistic_position_unit
   import spb_pkg::*;
#(
   parameter int unsigned FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   // particle input
   input  logic              req_valid,
   output logic              req_ready,
   input  fx_type            req_pos_x,
   input  fx_type            req_pos_y,
   input  fx_type            req_pos_z,
   input  fx_type            req_pos_bounce,
   input  fx_type            req_vel_x,
   input  fx_type            req_vel_y,
   input  fx_type            req_vel_z,
   input  fx_type            req_vel_bounce,
   input  fx_type            req_age,
   // position output
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output fx_type            rsp_out_x,
   output fx_type            rsp_out_y,
   output fx_type            rsp_out_z,
   output fx_type            rsp_out_bounce,
   // register port
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   cfg_type      cfg;
   particle_type in_part;
   scaled_type   mid_data;
   logic         mid_valid;
   logic         mid_ready;

   assign pready = 1'b1;

   assign in_part.pos[LANE_X]      = req_pos_x;
   assign in_part.pos[LANE_Y]      = req_pos_y;
   assign in_part.pos[LANE_Z]      = req_pos_z;
   assign in_part.pos[LANE_BOUNCE] = req_pos_bounce;
   assign in_part.vel[LANE_X]      = req_vel_x;
   assign in_part.vel[LANE_Y]      = req_vel_y;
   assign in_part.vel[LANE_Z]      = req_vel_z;
   assign in_part.vel[LANE_BOUNCE] = req_vel_bounce;

   spb_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .cfg     (cfg)
   );

   spb_scale #(
      .FRAC_BITS (FRAC_BITS)
   ) u_scale (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_part   (in_part),
      .in_age    (req_age),
      .out_valid (mid_valid),
      .out_ready (mid_ready),
      .out_data  (mid_data)
   );

   spb_lanes #(
      .FRAC_BITS (FRAC_BITS)
   ) u_lanes (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (mid_valid),
      .in_ready   (mid_ready),
      .in_data    (mid_data),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_x      (rsp_out_x),
      .out_y      (rsp_out_y),
      .out_z      (rsp_out_z),
      .out_bounce (rsp_out_bounce)
   );

endmodule

`default_nettype wire
